/* sv/sra_pkg.sv */
// Shared types, constants and the microcode table for the skyline rectangle allocator.
// Used by every module under sv/; depends on nothing else.
package sra_pkg;

  // Page geometry and limits.
  localparam int COLUMNS   = 256;
  localparam int MAX_PAGES = 2048;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int HGT_W     = COL_W + 1;
  localparam int SUM_W     = HGT_W + 1;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int PC_W      = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_PAGE_LIMIT = 2'd1;
  localparam logic [1:0] ST_NEVER_FITS = 2'd2;

  // Request command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Datapath operations, one per control word.
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_ACCEPT     = 4'd1;
  localparam logic [3:0] OP_START_RUN  = 4'd2;
  localparam logic [3:0] OP_CHECK      = 4'd3;
  localparam logic [3:0] OP_TAKE_RUN   = 4'd4;
  localparam logic [3:0] OP_INC_I      = 4'd5;
  localparam logic [3:0] OP_OPEN_PAGE  = 4'd6;
  localparam logic [3:0] OP_J_CLEAR    = 4'd7;
  localparam logic [3:0] OP_WRITE      = 4'd8;
  localparam logic [3:0] OP_EMIT_OK    = 4'd9;
  localparam logic [3:0] OP_RESTART    = 4'd10;
  localparam logic [3:0] OP_EMIT_NEVER = 4'd11;
  localparam logic [3:0] OP_EMIT_LIMIT = 4'd12;

  // Jump conditions.
  localparam logic [3:0] C_NEVER     = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_NO_ACCEPT = 4'd2;
  localparam logic [3:0] C_RESTART   = 4'd3;
  localparam logic [3:0] C_BAD_SIZE  = 4'd4;
  localparam logic [3:0] C_SCAN_DONE = 4'd5;
  localparam logic [3:0] C_V_GE_BEST = 4'd6;
  localparam logic [3:0] C_RUN_MORE  = 4'd7;
  localparam logic [3:0] C_FITS      = 4'd8;
  localparam logic [3:0] C_PAGE_FULL = 4'd9;

  // Microprogram step addresses.
  localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] S_DISPATCH  = 4'd1;
  localparam logic [PC_W-1:0] S_SCAN_HEAD = 4'd2;
  localparam logic [PC_W-1:0] S_CHECK     = 4'd3;
  localparam logic [PC_W-1:0] S_TAKE_RUN  = 4'd4;
  localparam logic [PC_W-1:0] S_NEXT_I    = 4'd5;
  localparam logic [PC_W-1:0] S_DECIDE    = 4'd6;
  localparam logic [PC_W-1:0] S_OPEN_PAGE = 4'd7;
  localparam logic [PC_W-1:0] S_J_CLEAR   = 4'd8;
  localparam logic [PC_W-1:0] S_WRITE     = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT_OK   = 4'd10;
  localparam logic [PC_W-1:0] S_RESTART   = 4'd11;
  localparam logic [PC_W-1:0] S_BADFIT    = 4'd12;
  localparam logic [PC_W-1:0] S_LIMIT     = 4'd13;

  // One control word: an operation and two prioritized conditional jumps.
  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      c1;
    logic [PC_W-1:0] t1;
    logic [3:0]      c2;
    logic [PC_W-1:0] t2;
  } cw_t;

  // Status flags from the datapath, sampled by the sequencer.
  typedef struct packed {
    logic accept;
    logic restart;
    logic bad_size;
    logic scan_done;
    logic v_ge_best;
    logic run_more;
    logic fits;
    logic page_full;
  } flags_t;

  // Height store access from the datapath.
  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [HGT_W-1:0] wr_data;
  } ram_req_t;

  // Read-only microprogram.
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '{op: OP_NOP, c1: C_ALWAYS, t1: S_IDLE, c2: C_NEVER, t2: S_IDLE};
    unique case (pc)
      S_IDLE:      cw = '{OP_ACCEPT,     C_NO_ACCEPT, S_IDLE,      C_NEVER,    S_IDLE};
      S_DISPATCH:  cw = '{OP_NOP,        C_RESTART,   S_RESTART,   C_BAD_SIZE, S_BADFIT};
      S_SCAN_HEAD: cw = '{OP_START_RUN,  C_SCAN_DONE, S_DECIDE,    C_NEVER,    S_IDLE};
      S_CHECK:     cw = '{OP_CHECK,      C_V_GE_BEST, S_NEXT_I,    C_RUN_MORE, S_CHECK};
      S_TAKE_RUN:  cw = '{OP_TAKE_RUN,   C_NEVER,     S_IDLE,      C_NEVER,    S_IDLE};
      S_NEXT_I:    cw = '{OP_INC_I,      C_ALWAYS,    S_SCAN_HEAD, C_NEVER,    S_IDLE};
      S_DECIDE:    cw = '{OP_NOP,        C_FITS,      S_J_CLEAR,   C_PAGE_FULL, S_LIMIT};
      S_OPEN_PAGE: cw = '{OP_OPEN_PAGE,  C_NEVER,     S_IDLE,      C_NEVER,    S_IDLE};
      S_J_CLEAR:   cw = '{OP_J_CLEAR,    C_NEVER,     S_IDLE,      C_NEVER,    S_IDLE};
      S_WRITE:     cw = '{OP_WRITE,      C_RUN_MORE,  S_WRITE,     C_NEVER,    S_IDLE};
      S_EMIT_OK:   cw = '{OP_EMIT_OK,    C_ALWAYS,    S_IDLE,      C_NEVER,    S_IDLE};
      S_RESTART:   cw = '{OP_RESTART,    C_ALWAYS,    S_IDLE,      C_NEVER,    S_IDLE};
      S_BADFIT:    cw = '{OP_EMIT_NEVER, C_ALWAYS,    S_IDLE,      C_NEVER,    S_IDLE};
      S_LIMIT:     cw = '{OP_EMIT_LIMIT, C_ALWAYS,    S_IDLE,      C_NEVER,    S_IDLE};
      default:     cw = '{OP_NOP,        C_ALWAYS,    S_IDLE,      C_NEVER,    S_IDLE};
    endcase
    return cw;
  endfunction

  // Operations that load the result register.
  function automatic logic is_emit(input logic [3:0] op);
    return (op == OP_EMIT_OK) || (op == OP_RESTART) ||
           (op == OP_EMIT_NEVER) || (op == OP_EMIT_LIMIT);
  endfunction

endpackage

/* sv/sra_height_ram.sv */
// Column height store: one write and one registered read port, with per-column valid bits
// so that reset, restart and a new page clear the skyline at once. Depends on sra_pkg.
module sra_height_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  sra_pkg::ram_req_t         req,
  output logic [sra_pkg::HGT_W-1:0] rd_data
);

  logic [sra_pkg::HGT_W-1:0]   mem [sra_pkg::COLUMNS];
  logic [sra_pkg::COLUMNS-1:0] valid;
  logic [sra_pkg::HGT_W-1:0]   rd_q;
  logic                        rd_hit;

  // Valid bits: cleared together, set by each write.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (req.rd_en) begin
      rd_hit <= valid[req.rd_addr];
    end
  end

  // A column never written since the last clear reads as zero.
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

/* sv/sra_sequencer.sv */
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on sra_pkg for the microprogram and the flag and control types.
module sra_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  sra_pkg::flags_t  flags,
  input  logic             out_busy,
  output logic [3:0]       op,
  output logic             idle
);

  logic [sra_pkg::PC_W-1:0] pc;
  logic [sra_pkg::PC_W-1:0] pc_next;
  sra_pkg::cw_t             cw;
  logic                     hold;

  function automatic logic cond_true(input logic [3:0] c, input sra_pkg::flags_t f);
    logic r;
    r = 1'b0;
    unique case (c)
      sra_pkg::C_NEVER:     r = 1'b0;
      sra_pkg::C_ALWAYS:    r = 1'b1;
      sra_pkg::C_NO_ACCEPT: r = !f.accept;
      sra_pkg::C_RESTART:   r = f.restart;
      sra_pkg::C_BAD_SIZE:  r = f.bad_size;
      sra_pkg::C_SCAN_DONE: r = f.scan_done;
      sra_pkg::C_V_GE_BEST: r = f.v_ge_best;
      sra_pkg::C_RUN_MORE:  r = f.run_more;
      sra_pkg::C_FITS:      r = f.fits;
      sra_pkg::C_PAGE_FULL: r = f.page_full;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  assign cw = sra_pkg::ucode(pc);

  // A result step waits while the previous result is still held.
  assign hold = sra_pkg::is_emit(cw.op) && out_busy;
  assign op   = hold ? sra_pkg::OP_NOP : cw.op;
  assign idle = (pc == sra_pkg::S_IDLE);

  // Next step: first jump, second jump, or fall through.
  always_comb begin
    priority if (hold) begin
      pc_next = pc;
    end else if (cond_true(cw.c1, flags)) begin
      pc_next = cw.t1;
    end else if (cond_true(cw.c2, flags)) begin
      pc_next = cw.t2;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sra_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sv/sra_datapath.sv */
// Allocator datapath: request, scan and page registers, height store access and the
// result register. Controlled by one operation code a cycle. Depends on sra_pkg.
module sra_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [3:0]                  op,
  input  logic                        accept,
  input  logic                        command,
  input  logic [sra_pkg::HGT_W-1:0]   rect_width,
  input  logic [sra_pkg::HGT_W-1:0]   rect_height,
  input  logic                        rsp_stall,
  input  logic [sra_pkg::HGT_W-1:0]   rd_data,
  output sra_pkg::ram_req_t           ram_req,
  output sra_pkg::flags_t             flags,
  output logic                        out_busy,
  output logic                        rsp_valid,
  output logic [1:0]                  status,
  output logic [sra_pkg::COL_W-1:0]   place_column,
  output logic [sra_pkg::COL_W-1:0]   place_row,
  output logic [sra_pkg::PAGE_W-1:0]  page_index
);

  logic                        cmd;
  logic [sra_pkg::HGT_W-1:0]   w;
  logic [sra_pkg::HGT_W-1:0]   h;
  logic [sra_pkg::COL_W-1:0]   i;
  logic [sra_pkg::COL_W-1:0]   j;
  logic [sra_pkg::HGT_W-1:0]   top;
  logic [sra_pkg::HGT_W-1:0]   best;
  logic [sra_pkg::COL_W-1:0]   col;
  logic                        found;
  logic [sra_pkg::PAGE_W-1:0]  page;
  logic [sra_pkg::HGT_W-1:0]   j_inc;
  logic [sra_pkg::SUM_W-1:0]   scan_end;
  logic [sra_pkg::SUM_W-1:0]   new_top;

  assign j_inc    = {1'b0, j} + sra_pkg::HGT_W'(1);
  assign scan_end = {2'b00, i} + {1'b0, w};
  assign new_top  = {1'b0, best} + {1'b0, h};

  // Conditions offered to the sequencer.
  always_comb begin
    flags.accept    = accept;
    flags.restart   = (cmd == sra_pkg::CMD_RESTART);
    flags.bad_size  = (w == '0) || (w >= sra_pkg::HGT_W'(sra_pkg::COLUMNS)) ||
                      (h > sra_pkg::HGT_W'(sra_pkg::COLUMNS));
    flags.scan_done = (scan_end >= sra_pkg::SUM_W'(sra_pkg::COLUMNS));
    flags.v_ge_best = (rd_data >= best);
    flags.run_more  = (j_inc != w);
    flags.fits      = found && (new_top <= sra_pkg::SUM_W'(sra_pkg::COLUMNS));
    flags.page_full = (page == sra_pkg::PAGE_W'(sra_pkg::MAX_PAGES - 1));
  end

  // Height store reads during the scan, writes while raising the placed columns.
  always_comb begin
    ram_req.clear   = (op == sra_pkg::OP_OPEN_PAGE) || (op == sra_pkg::OP_RESTART);
    ram_req.rd_en   = (op == sra_pkg::OP_START_RUN) || (op == sra_pkg::OP_CHECK);
    ram_req.rd_addr = (op == sra_pkg::OP_START_RUN) ? i : (i + j + 1'b1);
    ram_req.wr_en   = (op == sra_pkg::OP_WRITE);
    ram_req.wr_addr = col + j;
    ram_req.wr_data = new_top[sra_pkg::HGT_W-1:0];
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    unique case (op)
      sra_pkg::OP_ACCEPT: begin
        if (accept) begin
          cmd   <= command;
          w     <= rect_width;
          h     <= rect_height;
          i     <= '0;
          best  <= sra_pkg::HGT_W'(sra_pkg::COLUMNS);
          found <= 1'b0;
          col   <= '0;
        end
      end
      sra_pkg::OP_START_RUN: begin
        j   <= '0;
        top <= '0;
      end
      sra_pkg::OP_CHECK: begin
        if (rd_data > top) begin
          top <= rd_data;
        end
        j <= j + 1'b1;
      end
      sra_pkg::OP_TAKE_RUN: begin
        col   <= i;
        best  <= top;
        found <= 1'b1;
      end
      sra_pkg::OP_INC_I: begin
        i <= i + 1'b1;
      end
      sra_pkg::OP_OPEN_PAGE: begin
        col  <= '0;
        best <= '0;
      end
      sra_pkg::OP_J_CLEAR: begin
        j <= '0;
      end
      sra_pkg::OP_WRITE: begin
        j <= j + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Page counter.
  always_ff @(posedge clk) begin
    if (rst || (op == sra_pkg::OP_RESTART)) begin
      page <= '0;
    end else if (op == sra_pkg::OP_OPEN_PAGE) begin
      page <= page + 1'b1;
    end
  end

  // Result register: loaded by a result step, emptied when the beat is taken.
  assign out_busy = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (sra_pkg::is_emit(op)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      sra_pkg::OP_EMIT_OK: begin
        status       <= sra_pkg::ST_OK;
        place_column <= col;
        place_row    <= best[sra_pkg::COL_W-1:0];
        page_index   <= page;
      end
      sra_pkg::OP_RESTART, sra_pkg::OP_EMIT_NEVER, sra_pkg::OP_EMIT_LIMIT: begin
        priority if (op == sra_pkg::OP_EMIT_NEVER) begin
          status <= sra_pkg::ST_NEVER_FITS;
        end else if (op == sra_pkg::OP_EMIT_LIMIT) begin
          status <= sra_pkg::ST_PAGE_LIMIT;
        end else begin
          status <= sra_pkg::ST_OK;
        end
        place_column <= '0;
        place_row    <= '0;
        page_index   <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/skyline_rect_allocator_top.sv */
// Skyline rectangle allocator, top level: one request beat in, one result beat out.
// A restart or an oversize request goes from dispatch straight to its result step; an
// allocation reads each start column's run, drops it at a column not below the best,
// takes it otherwise, then writes the placed columns, opening a new page if none fit.
// One request is in flight at a time; a result may wait in its register meanwhile.
// Reset (synchronous, active high) clears all pages; no clearing pass is needed.
module skyline_rect_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        command,
  input  logic [sra_pkg::HGT_W-1:0]   rect_width,
  input  logic [sra_pkg::HGT_W-1:0]   rect_height,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic [sra_pkg::COL_W-1:0]   place_column,
  output logic [sra_pkg::COL_W-1:0]   place_row,
  output logic [sra_pkg::PAGE_W-1:0]  page_index
);

  logic                      idle;
  logic                      accept;
  logic                      out_busy;
  logic [3:0]                op;
  sra_pkg::flags_t           flags;
  sra_pkg::ram_req_t         ram_req;
  logic [sra_pkg::HGT_W-1:0] rd_data;

  // Requests are taken only at the idle step of the microprogram.
  assign req_stall = !idle;
  assign accept    = req_valid && idle;

  sra_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .out_busy (out_busy),
    .op       (op),
    .idle     (idle)
  );

  sra_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .accept       (accept),
    .command      (command),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .rsp_stall    (rsp_stall),
    .rd_data      (rd_data),
    .ram_req      (ram_req),
    .flags        (flags),
    .out_busy     (out_busy),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .place_column (place_column),
    .place_row    (place_row),
    .page_index   (page_index)
  );

  sra_height_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // An accepted request keeps the input side stalled on the next cycle.
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request side not stalled after accepting a beat");

  // Only defined status codes are delivered.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == sra_pkg::ST_OK || status == sra_pkg::ST_PAGE_LIMIT ||
                   status == sra_pkg::ST_NEVER_FITS))
    else $error("undefined status code on result");

  // Error results carry zero placement fields.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != sra_pkg::ST_OK) |->
      (place_column == '0 && place_row == '0 && page_index == '0))
    else $error("error result with nonzero placement");

  // The height store is never read and written in the same cycle.
  a_ram_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("height store read and write collide");

endmodule
